>>> src/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

>>> src/dotp_pkg.sv
package dotp_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] END_CODE   = 8'hff;
  localparam logic [7:0] PAD_CODE   = 8'h00;
  localparam logic [7:0] MSG_OPTION = 8'd53;
  localparam logic [7:0] COOKIE_0   = 8'h63;
  localparam logic [7:0] COOKIE_1   = 8'h82;
  localparam logic [7:0] COOKIE_2   = 8'h53;
  localparam logic [7:0] COOKIE_3   = 8'h63;
  localparam logic [2:0] COOKIE_LEN = 3'd4;

  typedef enum logic [2:0] {
    EV_COOKIE    = 3'd0,
    EV_VALUE     = 3'd1,
    EV_EMPTY     = 3'd2,
    EV_END       = 3'd3,
    EV_FRAME_END = 3'd4
  } event_kind_t;

  typedef enum logic [2:0] {
    MSG_NONE     = 3'd0,
    MSG_DISCOVER = 3'd1,
    MSG_OFFER    = 3'd2,
    MSG_REQUEST  = 3'd3,
    MSG_ACK      = 3'd4,
    MSG_RELEASE  = 3'd5,
    MSG_UNKNOWN  = 3'd6
  } msg_kind_t;

  typedef enum logic [1:0] {
    PH_COOKIE = 2'd0,
    PH_TYPE   = 2'd1,
    PH_LEN    = 2'd2,
    PH_VALUE  = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       frame_end;
  } dotp_in_t;

  typedef struct packed {
    event_kind_t event_kind;
    logic        is_dhcp;
    logic [7:0]  option_type;
    logic [7:0]  option_length;
    logic [7:0]  byte_index;
    logic [7:0]  value_byte;
    logic        option_done;
    logic [31:0] lead_word;
    msg_kind_t   message_kind;
    logic        truncated;
  } dotp_out_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       frame_end;
    logic       is_end_code;
    logic       is_pad;
    logic [3:0] cookie_hit;
  } dotp_item_t;

  function automatic msg_kind_t decode_msg(input logic [7:0] b);
    msg_kind_t k;
    case (b)
      8'd1:    k = MSG_DISCOVER;
      8'd2:    k = MSG_OFFER;
      8'd3:    k = MSG_REQUEST;
      8'd5:    k = MSG_ACK;
      8'd7:    k = MSG_RELEASE;
      default: k = MSG_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage

>>> src/dhcp_option_tlv_parser.sv
// An accepted byte is written into the queue; its result is then registered
// in the output register.
// Throughput: 1 byte per cycle while the queue is not full; the 4-entry queue
// decouples intake from the option walker, and the walker advances one byte
// per cycle while the output register is free or being taken.
// Reset (rst, synchronous): empties the queue, clears the output valid and
// returns the walker to awaiting the cookie.
module dhcp_option_tlv_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                src_valid,
  output logic                src_stall,
  input  dotp_pkg::dotp_in_t  src_item,
  output logic                res_valid,
  input  logic                res_stall,
  output dotp_pkg::dotp_out_t res_item
);
  import dotp_pkg::*;

  logic       pop;
  logic       q_valid;
  dotp_item_t q_item;

  dotp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_item  (src_item),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  dotp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

endmodule

>>> src/dotp_queue.sv
module dotp_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  dotp_pkg::dotp_item_t push_item,
  input  logic                pop,
  output logic                full,
  output logic                not_empty,
  output dotp_pkg::dotp_item_t head
);
  import dotp_pkg::*;

  dotp_item_t             slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]    wr_ptr;
  logic [QUEUE_AW-1:0]    rd_ptr;
  logic [QUEUE_AW:0]      count;

  assign full      = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

>>> src/dotp_front.sv
module dotp_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 src_valid,
  output logic                 src_stall,
  input  dotp_pkg::dotp_in_t   src_item,
  input  logic                 pop,
  output logic                 q_valid,
  output dotp_pkg::dotp_item_t q_item
);
  import dotp_pkg::*;

  dotp_item_t cls;
  logic       full;
  logic       push;

  always_comb begin
    cls.data_byte     = src_item.data_byte;
    cls.first_byte    = src_item.first_byte;
    cls.frame_end     = src_item.frame_end;
    cls.is_end_code   = (src_item.data_byte == END_CODE);
    cls.is_pad        = (src_item.data_byte == PAD_CODE);
    cls.cookie_hit[0] = (src_item.data_byte == COOKIE_0);
    cls.cookie_hit[1] = (src_item.data_byte == COOKIE_1);
    cls.cookie_hit[2] = (src_item.data_byte == COOKIE_2);
    cls.cookie_hit[3] = (src_item.data_byte == COOKIE_3);
  end

  assign src_stall = full;
  assign push      = src_valid && !full;

  dotp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (cls),
    .pop       (pop),
    .full      (full),
    .not_empty (q_valid),
    .head      (q_item)
  );

endmodule

>>> src/dotp_back.sv
module dotp_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  dotp_pkg::dotp_item_t q_item,
  output logic                 pop,
  output logic                 res_valid,
  input  logic                 res_stall,
  output dotp_pkg::dotp_out_t  res_item
);
  import dotp_pkg::*;

  phase_t      phase;
  logic [2:0]  cookie_pos;
  logic        cookie_match;
  logic [7:0]  cur_type;
  logic [7:0]  cur_len;
  logic [7:0]  value_count;
  logic [31:0] word_acc;

  phase_t      phase_next;
  logic [2:0]  cookie_pos_next;
  logic        cookie_match_next;
  logic [7:0]  cur_type_next;
  logic [7:0]  cur_len_next;
  logic [7:0]  value_count_next;
  logic [31:0] word_acc_next;

  phase_t      e_phase;
  logic [2:0]  e_pos;
  logic        e_match;
  logic [7:0]  e_type;
  logic [7:0]  e_len;
  logic [7:0]  e_count;
  logic [31:0] e_acc;

  logic [7:0]  d;
  logic        fend;
  logic        hit;
  logic        match_upd;
  logic        done;
  logic [31:0] acc_upd;
  logic        emit;
  dotp_out_t   res_next;

  assign pop  = q_valid && (!res_valid || !res_stall);
  assign d    = q_item.data_byte;
  assign fend = q_item.frame_end;

  always_comb begin
    if (q_item.first_byte) begin
      e_phase = PH_COOKIE;
      e_pos   = '0;
      e_match = 1'b1;
      e_type  = '0;
      e_len   = '0;
      e_count = '0;
      e_acc   = '0;
    end else begin
      e_phase = phase;
      e_pos   = cookie_pos;
      e_match = cookie_match;
      e_type  = cur_type;
      e_len   = cur_len;
      e_count = value_count;
      e_acc   = word_acc;
    end
  end

  always_comb begin
    hit       = q_item.cookie_hit[e_pos[1:0]];
    match_upd = e_match && hit;
    done      = ({1'b0, e_count} + 9'd1) >= {1'b0, e_len};
    acc_upd   = e_acc;
    if (e_count[7:2] == '0) begin
      case (e_count[1:0])
        2'd0:    acc_upd = e_acc | {d, 24'd0};
        2'd1:    acc_upd = e_acc | {8'd0, d, 16'd0};
        2'd2:    acc_upd = e_acc | {16'd0, d, 8'd0};
        default: acc_upd = e_acc | {24'd0, d};
      endcase
    end
  end

  // next state
  always_comb begin
    phase_next        = e_phase;
    cookie_pos_next   = e_pos;
    cookie_match_next = e_match;
    cur_type_next     = e_type;
    cur_len_next      = e_len;
    value_count_next  = e_count;
    word_acc_next     = e_acc;
    case (e_phase)
      PH_COOKIE: begin
        if (e_pos < COOKIE_LEN) begin
          cookie_match_next = match_upd;
          cookie_pos_next   = e_pos + 3'd1;
          if ((e_pos == COOKIE_LEN - 3'd1) && match_upd) begin
            phase_next = PH_TYPE;
          end
        end
      end
      PH_TYPE: begin
        if (q_item.is_end_code) begin
          phase_next      = PH_COOKIE;
          cookie_pos_next = COOKIE_LEN;
        end else if (!q_item.is_pad) begin
          cur_type_next = d;
          phase_next    = PH_LEN;
        end
      end
      PH_LEN: begin
        cur_len_next     = d;
        value_count_next = '0;
        word_acc_next    = '0;
        phase_next       = q_item.is_pad ? PH_TYPE : PH_VALUE;
      end
      PH_VALUE: begin
        word_acc_next    = acc_upd;
        value_count_next = e_count + 8'd1;
        if (done) begin
          phase_next = PH_TYPE;
        end
      end
      default: begin
        phase_next = PH_COOKIE;
      end
    endcase
    if (fend) begin
      phase_next      = PH_COOKIE;
      cookie_pos_next = COOKIE_LEN;
    end
  end

  // result
  always_comb begin
    emit     = 1'b0;
    res_next = '0;
    case (e_phase)
      PH_COOKIE: begin
        if (e_pos < COOKIE_LEN) begin
          if (e_pos == COOKIE_LEN - 3'd1) begin
            emit                = 1'b1;
            res_next.event_kind = EV_COOKIE;
            res_next.is_dhcp    = match_upd;
            res_next.truncated  = match_upd && fend;
          end else if (fend) begin
            emit                = 1'b1;
            res_next.event_kind = EV_FRAME_END;
            res_next.truncated  = 1'b1;
          end
        end
      end
      PH_TYPE: begin
        if (q_item.is_end_code) begin
          emit                 = 1'b1;
          res_next.event_kind  = EV_END;
          res_next.is_dhcp     = 1'b1;
          res_next.option_type = END_CODE;
        end else if (fend) begin
          emit                = 1'b1;
          res_next.event_kind = EV_FRAME_END;
          res_next.is_dhcp    = 1'b1;
          res_next.truncated  = 1'b1;
        end
      end
      PH_LEN: begin
        if (q_item.is_pad) begin
          emit                  = 1'b1;
          res_next.event_kind   = EV_EMPTY;
          res_next.is_dhcp      = 1'b1;
          res_next.option_type  = e_type;
          res_next.option_done  = 1'b1;
          res_next.message_kind = (e_type == MSG_OPTION) ? MSG_UNKNOWN : MSG_NONE;
          res_next.truncated    = fend;
        end else if (fend) begin
          emit                = 1'b1;
          res_next.event_kind = EV_FRAME_END;
          res_next.is_dhcp    = 1'b1;
          res_next.truncated  = 1'b1;
        end
      end
      PH_VALUE: begin
        emit                   = 1'b1;
        res_next.event_kind    = EV_VALUE;
        res_next.is_dhcp       = 1'b1;
        res_next.option_type   = e_type;
        res_next.option_length = e_len;
        res_next.byte_index    = e_count;
        res_next.value_byte    = d;
        res_next.option_done   = done;
        res_next.truncated     = fend;
        if (done) begin
          res_next.lead_word = acc_upd;
          if (e_type == MSG_OPTION) begin
            res_next.message_kind = decode_msg(acc_upd[31:24]);
          end
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_COOKIE;
      cookie_pos   <= '0;
      cookie_match <= 1'b1;
      cur_type     <= '0;
      cur_len      <= '0;
      value_count  <= '0;
      word_acc     <= '0;
      res_valid    <= 1'b0;
    end else begin
      if (pop) begin
        phase        <= phase_next;
        cookie_pos   <= cookie_pos_next;
        cookie_match <= cookie_match_next;
        cur_type     <= cur_type_next;
        cur_len      <= cur_len_next;
        value_count  <= value_count_next;
        word_acc     <= word_acc_next;
        res_valid    <= emit;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      res_item <= res_next;
    end
  end

endmodule

>>> src/dotp_checker.sv
`include "assert_macros.svh"

module dotp_checker (
  input logic                clk,
  input logic                rst,
  input logic                res_valid,
  input logic                res_stall,
  input dotp_pkg::dotp_out_t res_item
);
  import dotp_pkg::*;

  `ASSERT_NEXT(a_res_hold, clk, rst, res_valid && res_stall, res_valid && $stable(res_item))
  `ASSERT_IMP(a_idle_after_rst, clk, rst, $past(rst), !res_valid)
  `ASSERT_IMP(a_partial_clean, clk, rst, res_valid && (res_item.event_kind == EV_VALUE) && !res_item.option_done, (res_item.lead_word == '0) && (res_item.message_kind == MSG_NONE))
  `ASSERT_IMP(a_end_option, clk, rst, res_valid && (res_item.event_kind == EV_END), (res_item.option_type == END_CODE) && !res_item.truncated && res_item.is_dhcp)
  `ASSERT_IMP(a_mismatch_clean, clk, rst, res_valid && (res_item.event_kind == EV_COOKIE) && !res_item.is_dhcp, !res_item.truncated)

endmodule

bind dhcp_option_tlv_parser dotp_checker u_dotp_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res_item  (res_item)
);
